FILE: design/csmc_pkg.sv
package csmc_pkg;

  // Mode codes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_DISPLAY = 3'd1;
  localparam logic [2:0] MODE_SELECT  = 3'd2;
  localparam logic [2:0] MODE_AUTO    = 3'd3;
  localparam logic [2:0] MODE_MANUAL  = 3'd4;

  // Event codes
  localparam logic [1:0] OP_BUTTON_ONE = 2'd0;
  localparam logic [1:0] OP_BUTTON_TWO = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;
  localparam logic [1:0] OP_DETECTED   = 2'd3;

  // Action codes
  localparam logic [3:0] ACT_NONE         = 4'd0;
  localparam logic [3:0] ACT_SHOW_COUNTS  = 4'd1;
  localparam logic [3:0] ACT_SHOW_MENU    = 4'd2;
  localparam logic [3:0] ACT_DISPLAY_OFF  = 4'd3;
  localparam logic [3:0] ACT_CLEARED      = 4'd4;
  localparam logic [3:0] ACT_TICK_STOP    = 4'd5;
  localparam logic [3:0] ACT_ENTER_AUTO   = 4'd6;
  localparam logic [3:0] ACT_ENTER_MANUAL = 4'd7;
  localparam logic [3:0] ACT_LEAVE        = 4'd8;
  localparam logic [3:0] ACT_SORTED       = 4'd9;

  // Colour codes
  localparam logic [1:0] COLOR_RED   = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

  // Margin = floor(clear * 4 / 10), as clear * ceil(0.4 * 2^20) >> 20.
  // The rounding error stays below 0.04 over the 16-bit range, while the
  // true fraction of clear * 0.4 is never above 0.8, so the floor is exact.
  localparam int          MarginShift = 20;
  localparam logic [18:0] MarginRecip = 19'd419431;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] clear_level;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
  } item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] reference_clear;
    logic [14:0] detect_margin;
    logic [7:0]  total_count;
    logic [7:0]  red_count;
    logic [7:0]  green_count;
    logic [7:0]  blue_count;
  } state_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] action;
    logic [1:0] sorted_color;
    logic       object_found;
    logic [7:0] total_count;
    logic [7:0] red_count;
    logic [7:0] green_count;
    logic [7:0] blue_count;
  } result_t;

endpackage

FILE: design/color_sorter_mode_controller.sv
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: operation; tdata: sensor levels
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser: action; tdata: mode, colour, counts
//
// One event per cycle sustained while m_axis accepts; a result is offered once its
// event has passed the input register, one pass of step logic and the result register.
// Mode, reference and counters update as the event enters the result register.
// Reset (asynchronous, active low) returns to off with zero counters.
// A stall on m_axis holds the result; one further event waits in the input
// register before s_axis_tready drops.
module color_sorter_mode_controller import csmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] clear_level, [23:16] red_level, [31:24] green_level,
  // [39:32] blue_level
  input  logic [39:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] mode, [4:3] sorted_color, [5] object_found, [13:6] total_count,
  // [21:14] red_count, [29:22] green_count, [37:30] blue_count, [39:38] zero
  output logic [39:0] m_axis_tdata,
  // [3:0] action
  output logic [3:0]  m_axis_tuser
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  logic    advance;
  logic    in_take;

  // Move the held event into the result register when it is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  csmc_step u_step (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Input register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.operation   <= s_axis_tuser;
      in_item_q.clear_level <= s_axis_tdata[15:0];
      in_item_q.red_level   <= s_axis_tdata[23:16];
      in_item_q.green_level <= s_axis_tdata[31:24];
      in_item_q.blue_level  <= s_axis_tdata[39:32];
    end
  end

  // Controller state: advance with each event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.action;
  assign m_axis_tdata  = {2'b00,
                          out_res_q.blue_count,
                          out_res_q.green_count,
                          out_res_q.red_count,
                          out_res_q.total_count,
                          out_res_q.object_found,
                          out_res_q.sorted_color,
                          out_res_q.mode};

endmodule

FILE: design/csmc_step.sv
module csmc_step import csmc_pkg::*; (
  input  item_t   item_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [34:0] margin_prod;
  logic [14:0] new_margin;
  logic [16:0] clear_sum;
  logic        object_seen;
  logic [1:0]  pick_color;
  logic [3:0]  action;
  logic [1:0]  color;
  logic        found;
  logic        do_sort;
  state_t      nxt;

  // Scale the clear reading to four tenths for a new reference
  assign margin_prod = {19'b0, item_i.clear_level} * {16'b0, MarginRecip};
  assign new_margin  = margin_prod[MarginShift +: 15];

  // Object check: clear plus margin, without wrap, below the reference
  assign clear_sum   = {1'b0, item_i.clear_level} + {2'b0, state_i.detect_margin};
  assign object_seen = clear_sum < {1'b0, state_i.reference_clear};

  // Dominant colour; red needs a strict lead, green beats blue only strictly
  always_comb begin
    if (item_i.red_level > item_i.green_level && item_i.red_level > item_i.blue_level) begin
      pick_color = COLOR_RED;
    end else if (item_i.green_level > item_i.blue_level) begin
      pick_color = COLOR_GREEN;
    end else begin
      pick_color = COLOR_BLUE;
    end
  end

  // Mode transitions and counter updates
  always_comb begin
    nxt     = state_i;
    action  = ACT_NONE;
    color   = COLOR_RED;
    found   = 1'b0;
    do_sort = 1'b0;
    unique case (state_i.mode)
      MODE_DISPLAY: begin
        case (item_i.operation)
          OP_BUTTON_ONE: begin
            nxt.mode = MODE_OFF;
            action   = ACT_DISPLAY_OFF;
          end
          OP_BUTTON_TWO: begin
            nxt.total_count = '0;
            nxt.red_count   = '0;
            nxt.green_count = '0;
            nxt.blue_count  = '0;
            action          = ACT_CLEARED;
          end
          OP_TICK: action = ACT_TICK_STOP;
          default: ;
        endcase
      end
      MODE_SELECT: begin
        case (item_i.operation)
          OP_BUTTON_ONE: begin
            nxt.reference_clear = item_i.clear_level;
            nxt.detect_margin   = new_margin;
            nxt.mode            = MODE_AUTO;
            action              = ACT_ENTER_AUTO;
          end
          OP_BUTTON_TWO: begin
            nxt.reference_clear = item_i.clear_level;
            nxt.detect_margin   = new_margin;
            nxt.mode            = MODE_MANUAL;
            action              = ACT_ENTER_MANUAL;
          end
          default: ;
        endcase
      end
      MODE_AUTO: begin
        case (item_i.operation)
          OP_BUTTON_TWO: begin
            nxt.mode = MODE_OFF;
            action   = ACT_LEAVE;
          end
          OP_TICK:     found   = object_seen;
          OP_DETECTED: do_sort = 1'b1;
          default: ;
        endcase
      end
      MODE_MANUAL: begin
        case (item_i.operation)
          OP_BUTTON_ONE: found = object_seen;
          OP_BUTTON_TWO: begin
            nxt.mode = MODE_OFF;
            action   = ACT_LEAVE;
          end
          OP_TICK:     action  = ACT_TICK_STOP;
          OP_DETECTED: do_sort = 1'b1;
          default: ;
        endcase
      end
      default: begin
        // Off, and any unused code, behaves as off
        nxt.mode = MODE_OFF;
        case (item_i.operation)
          OP_BUTTON_ONE: begin
            nxt.mode = MODE_DISPLAY;
            action   = ACT_SHOW_COUNTS;
          end
          OP_BUTTON_TWO: begin
            nxt.mode = MODE_SELECT;
            action   = ACT_SHOW_MENU;
          end
          OP_TICK: action = ACT_TICK_STOP;
          default: ;
        endcase
      end
    endcase

    // Sort: advance the wrapping counters
    if (do_sort) begin
      color           = pick_color;
      action          = ACT_SORTED;
      nxt.total_count = state_i.total_count + 8'd1;
      case (pick_color)
        COLOR_RED:   nxt.red_count   = state_i.red_count + 8'd1;
        COLOR_GREEN: nxt.green_count = state_i.green_count + 8'd1;
        default:     nxt.blue_count  = state_i.blue_count + 8'd1;
      endcase
    end
  end

  assign state_o = nxt;

  // Result reflects the state after the event
  assign result_o.mode         = nxt.mode;
  assign result_o.action       = action;
  assign result_o.sorted_color = color;
  assign result_o.object_found = found;
  assign result_o.total_count  = nxt.total_count;
  assign result_o.red_count    = nxt.red_count;
  assign result_o.green_count  = nxt.green_count;
  assign result_o.blue_count   = nxt.blue_count;

endmodule

FILE: design/csmc_checker.sv
module csmc_checker import csmc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  logic [2:0] res_mode;
  logic       sorting_mode;

  assign res_mode     = m_axis_tdata[2:0];
  assign sorting_mode = (res_mode == MODE_AUTO) || (res_mode == MODE_MANUAL);

  // Hold a waiting event until it is taken
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("waiting event changed");

  // Hold a stalled result
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A sort only happens in a sorting mode, and picks a real colour
  a_sort_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ACT_SORTED |->
      sorting_mode && m_axis_tdata[4:3] != 2'd3)
    else $error("sort outside a sorting mode");

  // A found object comes from a check, which carries no action
  a_found_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> sorting_mode && m_axis_tuser == ACT_NONE)
    else $error("object reported outside a check");

  // Entering a sorting mode lands in the matching mode
  a_enter_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_ENTER_AUTO || m_axis_tuser == ACT_ENTER_MANUAL) |->
      (m_axis_tuser == ACT_ENTER_AUTO) == (res_mode == MODE_AUTO) && sorting_mode)
    else $error("enter action with wrong mode");

endmodule

bind color_sorter_mode_controller csmc_checker u_csmc_checker (.*);
